// ===== design/fptd_pkg.sv =====
package fptd_pkg;

	localparam int MAX_TASKS_DEF       = 8;
	localparam int PRIORITY_LEVELS_DEF = 10;
	localparam int RESULT_CAP          = 8;
	localparam int PRIO_SLOTS          = 32 / 4;

	localparam logic [31:0] WAKE_RESET = 32'd1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRIORITIES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCHED_ENABLED   = 2'd2;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_DELAY = 1'b1;

	typedef struct packed {
		logic        wr_en;
		logic [3:0]  wr_slot;
		logic [31:0] delay;
	} wake_wr_t;

endpackage

// ===== design/fptd_wake.sv =====
module fptd_wake #(
	parameter int MAX_TASKS = fptd_pkg::MAX_TASKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fptd_pkg::wake_wr_t           wr,
	input  logic [31:0]                  tick,
	input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
	output logic                         due
);

	localparam int IDX_W = $clog2(MAX_TASKS);

	logic [31:0]      wake_q [MAX_TASKS];
	logic [IDX_W-1:0] wr_addr;

	assign wr_addr = wr.wr_slot[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				wake_q[i] <= fptd_pkg::WAKE_RESET;
			end
		end else if (wr.wr_en) begin
			wake_q[wr_addr] <= tick + wr.delay;
		end
	end

	// shared unsigned compare, one slot per cycle
	assign due = (tick >= wake_q[rd_addr]);

endmodule

// ===== design/fixed_priority_tick_dispatcher_top.sv =====
// Delay word: taken while idle, no result, busy stays low; a tick word while disabled does the same.
// Tick word: counter advances, then every slot's wake tick goes through the shared comparator,
// then priority levels are searched from PRIORITY_LEVELS-1 down, one result per ready slot,
// ending on the last result (at most RESULT_CAP) or when no ready slot or level is left.
// Results come one per strobe cycle; the receiver cannot stall.
// Reset: counter 0, all wake ticks 1, configuration 0, block idle.
module fixed_priority_tick_dispatcher_top #(
	parameter int MAX_TASKS       = fptd_pkg::MAX_TASKS_DEF,
	parameter int PRIORITY_LEVELS = fptd_pkg::PRIORITY_LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [2:0]                    task_id,
	input  logic [31:0]                   delay_ticks,
	output logic                          strobe,
	output logic [2:0]                    run_task,
	output logic [31:0]                   tick_now,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fptd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int LVL_W = $clog2(PRIORITY_LEVELS);
	localparam int RC_W  = $clog2(fptd_pkg::RESULT_CAP + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;

	logic [3:0]  task_count_q;
	logic [31:0] task_prio_q;
	logic        enabled_q;
	logic [31:0] tick_q;

	logic [IDX_W-1:0]     idx_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [RC_W-1:0]      cnt_q;
	logic [MAX_TASKS-1:0] ready_q;

	logic                 accept;
	logic [4:0]           tc_ext;
	logic [CNT_W-1:0]     n_eff;
	logic [3:0]           prio_of [MAX_TASKS];
	logic [MAX_TASKS-1:0] elig;
	logic [MAX_TASKS-1:0] match;
	logic [MAX_TASKS-1:0] rest;
	logic [IDX_W-1:0]     sel;
	logic [4:0]           sel_ext;
	logic                 last_hit;
	logic                 due;
	fptd_pkg::wake_wr_t   wake_wr;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign tc_ext = {1'b0, task_count_q};
	assign n_eff  = (tc_ext > 5'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(tc_ext);

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_slot
		if (g < fptd_pkg::PRIO_SLOTS) begin : g_prio
			assign prio_of[g] = task_prio_q[4*g +: 4];
		end else begin : g_zero
			assign prio_of[g] = 4'd0;
		end
		assign elig[g]  = (5'(g) < 5'(n_eff)) &&
			({1'b0, prio_of[g]} < 5'(PRIORITY_LEVELS));
		assign match[g] = ready_q[g] && ({1'b0, prio_of[g]} == 5'(lvl_q));
	end

	always_comb begin
		sel = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (match[i]) begin
				sel = IDX_W'(i);
			end
		end
	end

	assign sel_ext  = 5'(sel);
	assign rest     = ready_q & ~(MAX_TASKS'(1) << sel);
	assign last_hit = (rest == '0) || (cnt_q == RC_W'(fptd_pkg::RESULT_CAP - 1));

	assign wake_wr.wr_en   = accept && (func == fptd_pkg::FUNC_DELAY) &&
		({2'b00, task_id} < 5'(n_eff));
	assign wake_wr.wr_slot = {1'b0, task_id};
	assign wake_wr.delay   = delay_ticks;

	fptd_wake #(
		.MAX_TASKS(MAX_TASKS)
	) u_wake (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wake_wr),
		.tick   (tick_q),
		.rd_addr(idx_q),
		.due    (due)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			task_prio_q  <= '0;
			enabled_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fptd_pkg::CFG_TASK_COUNT:      task_count_q <= cfg_data[3:0];
				fptd_pkg::CFG_TASK_PRIORITIES: task_prio_q  <= cfg_data;
				fptd_pkg::CFG_SCHED_ENABLED:   enabled_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			idx_q   <= '0;
			lvl_q   <= '0;
			cnt_q   <= '0;
			ready_q <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (func == fptd_pkg::FUNC_TICK) && enabled_q) begin
						tick_q  <= tick_q + 32'd1;
						idx_q   <= '0;
						ready_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					ready_q[idx_q] <= due && elig[idx_q];
					if (idx_q == IDX_W'(MAX_TASKS - 1)) begin
						lvl_q   <= LVL_W'(PRIORITY_LEVELS - 1);
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (ready_q == '0) begin
						state_q <= ST_IDLE;
					end else if (match != '0) begin
						strobe   <= 1'b1;
						ready_q  <= rest;
						cnt_q    <= cnt_q + 1'b1;
						if (last_hit) begin
							state_q <= ST_IDLE;
						end
					end else if (lvl_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && ready_q != '0 && match != '0) begin
			run_task <= sel_ext[2:0];
			tick_now <= tick_q;
			last     <= last_hit;
		end
	end

endmodule

// ===== design/fptd_checker.sv =====
module fptd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        func,
	input logic        strobe,
	input logic        last,
	input logic [2:0]  run_task,
	input logic [31:0] tick_now
);

	// more results pending keeps the block busy
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("busy low with results still pending");

	// all results of one tick share one tick value
	a_tick_same: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> $stable(tick_now))
		else $error("tick_now changed within one tick");

	// a slot is not reported twice in a row within one tick
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> !strobe || run_task != $past(run_task))
		else $error("slot repeated within one tick");

	// a freshly taken tick cannot produce a result in the next cycle
	a_scan_first: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !func |=> !strobe)
		else $error("result before the wake scan");

endmodule

bind fixed_priority_tick_dispatcher_top fptd_checker u_fptd_checker (.*);

// ===== tb/fixed_priority_tick_dispatcher_checker.sv =====
module fixed_priority_tick_dispatcher_checker
	import fptd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 func,
	input  logic [2:0]           task_id,
	input  logic [31:0]          delay_ticks,
	input  logic                 strobe,
	input  logic [2:0]           run_task,
	input  logic [31:0]          tick_now,
	input  logic                 last,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 eot,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [2:0]  slot;
		logic [31:0] tick;
		logic        last;
	} dispatch_t;

	dispatch_t   due_q[$];
	dispatch_t   exp;
	logic [3:0]  cnt_reg;
	logic [31:0] prio_reg;
	logic        en_reg;
	logic [31:0] now_tick;
	logic [31:0] wake [MAX_TASKS_DEF];
	bit          eot_seen;

	task automatic report(input string msg);
		errors++;
		$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	task automatic predict_word(input logic f, input logic [2:0] id, input logic [31:0] d);
		int unsigned n;
		dispatch_t   r;
		dispatch_t   batch[$];
		n = (cnt_reg > MAX_TASKS_DEF) ? MAX_TASKS_DEF : cnt_reg;
		if (f == FUNC_DELAY) begin
			if (id < n)
				wake[id] = now_tick + d;
			return;
		end
		if (!en_reg)
			return;
		now_tick = now_tick + 32'd1;
		for (int lvl = PRIORITY_LEVELS_DEF - 1; lvl >= 0; lvl--) begin
			for (int i = 0; i < n; i++) begin
				if (prio_reg[4*i +: 4] == 4'(lvl) && now_tick >= wake[i] &&
				    batch.size() < RESULT_CAP) begin
					r.slot = 3'(i);
					r.tick = now_tick;
					r.last = 1'b0;
					batch.push_back(r);
				end
			end
		end
		if (batch.size() > 0) begin
			r = batch.pop_back();
			r.last = 1'b1;
			batch.push_back(r);
		end
		foreach (batch[k])
			due_q.push_back(batch[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_reg = '0;
			prio_reg = '0;
			en_reg = 1'b0;
			now_tick = '0;
			for (int i = 0; i < MAX_TASKS_DEF; i++)
				wake[i] = WAKE_RESET;
			due_q.delete();
			eot_seen = 1'b0;
			errors = 0;
			pending = 0;
		end else begin
			if (strobe) begin
				if (due_q.size() == 0) begin
					report($sformatf("unexpected dispatch: slot %0d tick %0d last %0b",
						run_task, tick_now, last));
				end else begin
					exp = due_q.pop_front();
					if (run_task !== exp.slot)
						report($sformatf("run_task %0d, want %0d", run_task, exp.slot));
					if (tick_now !== exp.tick)
						report($sformatf("tick_now %0d, want %0d", tick_now, exp.tick));
					if (last !== exp.last)
						report($sformatf("last %0b, want %0b (slot %0d)",
							last, exp.last, exp.slot));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TASK_COUNT:      cnt_reg = cfg_data[3:0];
					CFG_TASK_PRIORITIES: prio_reg = cfg_data;
					CFG_SCHED_ENABLED:   en_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				predict_word(func, task_id, delay_ticks);
			if (eot && !eot_seen) begin
				eot_seen = 1'b1;
				if (due_q.size() != 0)
					report($sformatf("%0d dispatches never arrived", due_q.size()));
			end
			pending = due_q.size();
		end
	end

endmodule

// ===== tb/fixed_priority_tick_dispatcher_top_tb.sv =====
module fixed_priority_tick_dispatcher_top_tb;
	import fptd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYC  = 40;
	localparam int PHASE_WORDS = 75;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 func;
	logic [2:0]           task_id;
	logic [31:0]          delay_ticks;
	logic                 strobe;
	logic [2:0]           run_task;
	logic [31:0]          tick_now;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 eot;
	int                   errors;
	int                   pending;
	int                   idle_pct;
	int                   quiet;

	fixed_priority_tick_dispatcher_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.task_id     (task_id),
		.delay_ticks (delay_ticks),
		.strobe      (strobe),
		.run_task    (run_task),
		.tick_now    (tick_now),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	fixed_priority_tick_dispatcher_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.task_id     (task_id),
		.delay_ticks (delay_ticks),
		.strobe      (strobe),
		.run_task    (run_task),
		.tick_now    (tick_now),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.eot         (eot),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("fixed_priority_tick_dispatcher_top: mismatch");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [31:0] rand_prio();
		logic [31:0] p;
		for (int i = 0; i < 8; i++)
			p[4*i +: 4] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
			                                          : 4'($urandom_range(0, 9));
		return p;
	endfunction

	task automatic send_word(input logic f, input logic [2:0] id, input logic [31:0] d);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
			start = 1'b0;
			func = 1'($urandom);
			task_id = 3'($urandom);
			delay_ticks = $urandom;
			// mostly short gaps, some long enough to land mid-scan
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 4))
				@(negedge clk);
		end
		start = 1'b1;
		func = f;
		task_id = id;
		delay_ticks = d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input logic [3:0] cnt, input logic [31:0] prio, input logic en);
		settle();
		cfg_write(CFG_TASK_COUNT, {28'd0, cnt});
		cfg_write(CFG_TASK_PRIORITIES, prio);
		cfg_write(CFG_SCHED_ENABLED, {31'd0, en});
	endtask

	initial begin
		logic        f;
		logic [31:0] d;
		int          sel;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_TICK;
		task_id = '0;
		delay_ticks = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TASK_COUNT;
		cfg_data = '0;
		eot = 1'b0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// disabled, no slots
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_DELAY, 3'd0, 32'd5);

		// oversized count, priorities 9,0,2,5,10,0,15,9 for slots 0..7
		configure(4'd15, 32'h9F0A_5209, 1'b0);
		send_word(FUNC_DELAY, 3'd7, 32'hFFFF_FFFF);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		settle();
		cfg_write(CFG_SCHED_ENABLED, 32'd1);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_DELAY, 3'd0, 32'd0);
		send_word(FUNC_DELAY, 3'd1, 32'd3);
		send_word(FUNC_DELAY, 3'd3, 32'hFFFF_FFFF);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_DELAY, 3'd7, 32'd0);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_TICK, 3'd0, 32'd0);

		// nothing dispatchable, counter still moves
		configure(4'd8, 32'hFFFF_FFFF, 1'b1);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_TICK, 3'd0, 32'd0);

		// all at lowest level, three slots
		configure(4'd3, 32'h0000_0000, 1'b1);
		send_word(FUNC_DELAY, 3'd5, 32'd0);
		send_word(FUNC_DELAY, 3'd2, 32'd2);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_TICK, 3'd0, 32'd0);
		send_word(FUNC_TICK, 3'd0, 32'd0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(4'd8, rand_prio(), 1'b1);
				1: configure(4'd15, rand_prio(), 1'b1);
				2: configure(4'($urandom_range(1, 7)), rand_prio(), 1'b1);
				3: configure(4'd8, 32'h0000_0000, 1'b1);
				4: configure(4'($urandom_range(0, 15)), rand_prio(), $urandom_range(0, 3) != 0);
				default: configure(4'd8, rand_prio(), 1'b1);
			endcase
			case (ph % 4)
				1: idle_pct = 62;
				3: idle_pct = 23;
				default: idle_pct = 0;
			endcase
			for (int k = 0; k < PHASE_WORDS; k++) begin
				f = ($urandom_range(0, 99) < 55) ? FUNC_TICK : FUNC_DELAY;
				sel = $urandom_range(0, 99);
				if (sel < 60)
					d = $urandom_range(0, 12);
				else if (sel < 75)
					d = $urandom;
				else if (sel < 90)
					d = 32'hFFFF_FFFF - $urandom_range(0, 5);
				else
					d = $urandom_range(13, 200);
				send_word(f, 3'($urandom_range(0, 7)), d);
			end
		end
		idle_pct = 0;

		settle();
		eot = 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("fixed_priority_tick_dispatcher_top: match");
		else
			$display("fixed_priority_tick_dispatcher_top: mismatch");
		$finish;
	end

endmodule
